// File: rtl/lodd_pkg.sv
// Package for the lock-order deadlock detector: sizes, command codes and
// status codes. No dependencies.
`default_nettype none
package lodd_pkg;
    localparam int LockCount  = 32;
    localparam int StackDepth = 16;
    localparam int IdW        = $clog2(LockCount);
    localparam int SpW        = $clog2(StackDepth);
    localparam int CntW       = $clog2(StackDepth + 1);
    localparam int DfsW       = $clog2(LockCount + 1);

    typedef enum logic [0:0] {
        CMD_ACQUIRE = 1'b0,
        CMD_RELEASE = 1'b1
    } t_cmd;

    typedef enum logic [2:0] {
        ST_OK             = 3'd0,
        ST_DEADLOCK       = 3'd1,
        ST_MULTI_UNLOCK   = 3'd2,
        ST_INVALID_UNLOCK = 3'd3,
        ST_OVERFLOW       = 3'd4,
        ST_HALTED         = 3'd5
    } t_status;
endpackage
`default_nettype wire

// File: rtl/lock_order_deadlock_detector.sv
// Top level of the lock-order deadlock detector: lock stack, order matrix
// and an iterative depth-first search engine. Depends on lodd_pkg.
`default_nettype none
// Each beat on the input carries an acquire or release of one lock id and
// produces exactly one result beat. An acquire that adds a new lock-order
// edge starts a depth-first search over the order matrix. The search examines
// one candidate per cycle: the pass over the roots checks one id at a time,
// and each visited node scans every neighbor and is then popped. A deadlock
// ends the search early. The block is not ready while it searches. A result
// waits in the output register until taken. Any fault halts the block until
// reset.
module lock_order_deadlock_detector (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,  // [0] command, [5:1] lock_id
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata   // [2:0] status, [7:3] cycle_from,
                                            // [12:8] cycle_to
);
    localparam int IW = lodd_pkg::IdW;
    localparam int LC = lodd_pkg::LockCount;

    typedef enum logic [2:0] {
        S_IDLE, S_ROOT, S_SCAN, S_DONE, S_OUT
    } t_state;

    t_state r_state;
    logic [LC-1:0] r_edges [LC];
    logic [LC-1:0] r_seen, r_visited, r_finished;
    logic [IW-1:0] r_held [lodd_pkg::StackDepth];
    logic [lodd_pkg::CntW-1:0] r_count;
    logic r_halted;
    logic [IW:0]   r_order [LC];
    logic [IW-1:0] r_snode [LC];
    logic [IW-1:0] r_snext [LC];
    logic [lodd_pkg::DfsW-1:0] r_sp;
    logic [IW:0]   r_root;
    logic [IW:0]   r_vcnt;
    logic [IW:0]   r_n;
    logic [IW-1:0] r_id;
    logic [2:0]    r_status;
    logic [IW-1:0] r_from, r_to;

    logic [IW-1:0] w_h, w_n, w_top;
    logic [lodd_pkg::DfsW-1:0] w_spm1;

    assign w_spm1 = r_sp - 1'b1;
    assign w_h = r_snode[w_spm1[IW-1:0]];
    assign w_n = r_n[IW-1:0];
    assign w_top = r_held[r_count[lodd_pkg::SpW-1:0] - 1'b1];
    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = (r_state == S_OUT);
    assign m_axis_tdata = {3'b000, r_to, r_from, r_status};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_seen   <= '0;
            r_count  <= '0;
            r_halted <= 1'b0;
            for (int i = 0; i < LC; i++) r_edges[i] <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: if (s_axis_tvalid) begin
                    r_id   <= s_axis_tdata[IW:1];
                    r_from <= '0;
                    r_to   <= '0;
                    if (r_halted) begin
                        r_status <= lodd_pkg::ST_HALTED;
                        r_state  <= S_OUT;
                    end else if (s_axis_tdata[0] == lodd_pkg::CMD_ACQUIRE) begin
                        r_seen[s_axis_tdata[IW:1]] <= 1'b1;
                        if (r_count >= lodd_pkg::CntW'(lodd_pkg::StackDepth)) begin
                            r_status <= lodd_pkg::ST_OVERFLOW;
                            r_halted <= 1'b1;
                            r_state  <= S_OUT;
                        end else if (r_count != '0 && w_top != s_axis_tdata[IW:1]
                                     && !r_edges[w_top][s_axis_tdata[IW:1]]) begin
                            r_edges[w_top][s_axis_tdata[IW:1]] <= 1'b1;
                            r_status   <= lodd_pkg::ST_OK;
                            r_visited  <= '0;
                            r_finished <= '0;
                            r_root     <= '0;
                            r_vcnt     <= '0;
                            r_state    <= S_ROOT;
                        end else begin
                            r_held[r_count[lodd_pkg::SpW-1:0]] <= s_axis_tdata[IW:1];
                            r_count  <= r_count + 1'b1;
                            r_status <= lodd_pkg::ST_OK;
                            r_state  <= S_OUT;
                        end
                    end else begin
                        r_state <= S_OUT;
                        if (r_count == '0) begin
                            r_status <= lodd_pkg::ST_MULTI_UNLOCK;
                            r_halted <= 1'b1;
                        end else if (w_top != s_axis_tdata[IW:1]) begin
                            r_status <= lodd_pkg::ST_INVALID_UNLOCK;
                            r_halted <= 1'b1;
                        end else begin
                            r_status <= lodd_pkg::ST_OK;
                            r_count  <= r_count - 1'b1;
                        end
                    end
                end
                // Pick the next unvisited seen root, one id per cycle.
                S_ROOT: begin
                    if (r_root[IW]) begin
                        r_state <= S_DONE;
                    end else begin
                        if (r_seen[r_root[IW-1:0]] && !r_visited[r_root[IW-1:0]]) begin
                            r_order[r_root[IW-1:0]]   <= r_vcnt;
                            r_vcnt                    <= r_vcnt + 1'b1;
                            r_visited[r_root[IW-1:0]] <= 1'b1;
                            r_snode[0] <= r_root[IW-1:0];
                            r_n        <= '0;
                            r_sp       <= lodd_pkg::DfsW'(1);
                            r_state    <= S_SCAN;
                        end
                        r_root <= r_root + 1'b1;
                    end
                end
                // One candidate neighbor of the node on top per cycle.
                S_SCAN: begin
                    if (r_n[IW]) begin
                        r_finished[w_h] <= 1'b1;
                        r_sp <= w_spm1;
                        if (w_spm1 == '0) r_state <= S_ROOT;
                        else r_n <= {1'b0, r_snext[w_spm1[IW-1:0] - 1'b1]} +
                                    (r_snext[w_spm1[IW-1:0] - 1'b1] == '0 ?
                                     (IW+1)'(LC) : '0);
                    end else if (!r_edges[w_h][w_n]) begin
                        r_n <= r_n + 1'b1;
                    end else if (!r_visited[w_n]) begin
                        r_snext[w_spm1[IW-1:0]] <= w_n + 1'b1;
                        r_order[w_n]   <= r_vcnt;
                        r_vcnt         <= r_vcnt + 1'b1;
                        r_visited[w_n] <= 1'b1;
                        r_snode[r_sp[IW-1:0]] <= w_n;
                        r_sp <= r_sp + 1'b1;
                        r_n  <= '0;
                    end else if (r_order[w_h] >= r_order[w_n] && !r_finished[w_n]) begin
                        r_status <= lodd_pkg::ST_DEADLOCK;
                        r_from   <= w_h;
                        r_to     <= w_n;
                        r_halted <= 1'b1;
                        r_state  <= S_OUT;
                    end else begin
                        r_n <= r_n + 1'b1;
                    end
                end
                S_DONE: begin
                    r_held[r_count[lodd_pkg::SpW-1:0]] <= r_id;
                    r_count <= r_count + 1'b1;
                    r_state <= S_OUT;
                end
                S_OUT: if (m_axis_tready) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// File: rtl/lodd_checker.sv
// Port-level checker for the lock-order deadlock detector, bound to the
// top level. Depends on lodd_pkg.
`default_nettype none
module lodd_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [15:0] m_axis_tdata
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result beat dropped or changed while stalled");
    a_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[2:0] <= 3'(lodd_pkg::ST_HALTED))
        else $error("undefined status code");
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[2:0] != 3'(lodd_pkg::ST_DEADLOCK)
        |-> m_axis_tdata[12:3] == '0)
        else $error("back edge reported without deadlock");
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input taken while a result is pending");
    // Every fault is sticky, so the next result beat after any fault is halted.
    a_halt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready && m_axis_tdata[2:0] != 3'(lodd_pkg::ST_OK)
        ##1 (m_axis_tvalid && m_axis_tready)[->1]
        |-> m_axis_tdata[2:0] == 3'(lodd_pkg::ST_HALTED))
        else $error("result after a fault is not halted");
endmodule

bind lock_order_deadlock_detector lodd_checker u_lodd_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
);
`default_nettype wire

// File: tb/sv/tb_lock_order_deadlock_detector.sv
// Self-checking testbench for the lock-order deadlock detector.
// Depends on lodd_pkg and lock_order_deadlock_detector; checks every result beat.
`timescale 1ns / 100ps

module tb_lock_order_deadlock_detector;

    localparam int CycleLimit = 2_000_000;

    typedef struct packed {
        logic [31:0][31:0] edges;
        logic [31:0]       seen;
        logic [15:0][4:0]  held;
        logic [4:0]        depth;
        logic              halted;
    } t_lock_graph;

    typedef struct packed {
        lodd_pkg::t_status status;
        logic [4:0]        src;
        logic [4:0]        dst;
    } t_lock_result;

    typedef struct packed {
        lodd_pkg::t_cmd cmd;
        logic [4:0]     id;
        logic           fixed;
        t_lock_result   want;
    } t_lock_beat;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;   // [0] command, [5:1] lock_id
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;   // [2:0] status, [7:3] cycle_from, [12:8] cycle_to

    t_lock_graph  plan_state;
    t_lock_beat   beat_plan[$];
    t_lock_result pending_results[$];
    int           mismatches;
    int           accepted_beats;
    int           cycles;
    bit           calm;

    lock_order_deadlock_detector DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        cycles = 0;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CycleLimit) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Iterative depth-first search over the order graph; roots and neighbors
    // are taken in ascending id order, and the first back edge wins.
    function automatic bit find_back_edge(input t_lock_graph g, output logic [4:0] src,
                                          output logic [4:0] dst);
        int          order[32];
        int          node[32];
        int          nxt[32];
        logic [31:0] visited;
        logic [31:0] finished;
        int          sp;
        int          count;
        int          h;
        int          n;
        visited  = '0;
        finished = '0;
        count    = 0;
        src      = '0;
        dst      = '0;
        for (int root = 0; root < 32; root++) begin
            if (!g.seen[root] || visited[root]) continue;
            order[root] = count;
            count++;
            visited[root] = 1'b1;
            node[0] = root;
            nxt[0]  = 0;
            sp      = 1;
            while (sp > 0) begin
                h = node[sp-1];
                n = nxt[sp-1];
                while (n < 32 && !g.edges[h][n]) n++;
                if (n >= 32) begin
                    finished[h] = 1'b1;
                    sp--;
                    continue;
                end
                nxt[sp-1] = n + 1;
                if (!visited[n]) begin
                    order[n] = count;
                    count++;
                    visited[n] = 1'b1;
                    if (sp < 32) begin
                        node[sp] = n;
                        nxt[sp]  = 0;
                        sp++;
                    end
                    continue;
                end
                if (order[h] < order[n]) continue;
                if (!finished[n]) begin
                    src = h[4:0];
                    dst = n[4:0];
                    return 1'b1;
                end
            end
        end
        return 1'b0;
    endfunction

    function automatic t_lock_graph apply_beat(input t_lock_graph g,
                                               input lodd_pkg::t_cmd cmd,
                                               input logic [4:0] id,
                                               output t_lock_result r);
        logic [4:0] top;
        logic [4:0] f;
        logic [4:0] t;
        bit         dead;
        r.status = lodd_pkg::ST_OK;
        r.src    = '0;
        r.dst    = '0;
        dead     = 1'b0;
        if (g.halted) begin
            r.status = lodd_pkg::ST_HALTED;
        end else if (cmd == lodd_pkg::CMD_ACQUIRE) begin
            g.seen[id] = 1'b1;
            if (g.depth >= 5'd16) begin
                r.status = lodd_pkg::ST_OVERFLOW;
                g.halted = 1'b1;
            end else begin
                if (g.depth > 0) begin
                    top = g.held[g.depth-1];
                    if (top != id && !g.edges[top][id]) begin
                        g.edges[top][id] = 1'b1;
                        dead = find_back_edge(g, f, t);
                    end
                end
                if (dead) begin
                    r.status = lodd_pkg::ST_DEADLOCK;
                    r.src    = f;
                    r.dst    = t;
                    g.halted = 1'b1;
                end else begin
                    g.held[g.depth] = id;
                    g.depth++;
                end
            end
        end else begin
            if (g.depth == 0) begin
                r.status = lodd_pkg::ST_MULTI_UNLOCK;
                g.halted = 1'b1;
            end else if (g.held[g.depth-1] != id) begin
                r.status = lodd_pkg::ST_INVALID_UNLOCK;
                g.halted = 1'b1;
            end else begin
                g.depth--;
            end
        end
        return g;
    endfunction

    function automatic lodd_pkg::t_status status_of(input lodd_pkg::t_cmd cmd,
                                                    input logic [4:0] id);
        t_lock_result r;
        t_lock_graph  g;
        g = apply_beat(plan_state, cmd, id, r);
        return r.status;
    endfunction

    // Plans one beat; a fixed beat carries its typed-in answer instead of the
    // predicted one.
    task automatic plan_beat(input lodd_pkg::t_cmd cmd, input logic [4:0] id,
                             input bit fixed, input lodd_pkg::t_status st);
        t_lock_beat   b;
        t_lock_result r;
        plan_state = apply_beat(plan_state, cmd, id, r);
        b.cmd   = cmd;
        b.id    = id;
        b.fixed = fixed;
        b.want  = r;
        if (fixed) begin
            b.want.status = st;
            b.want.src    = '0;
            b.want.dst    = '0;
        end
        beat_plan.push_back(b);
    endtask

    task automatic build_plan();
        logic [4:0] id;
        logic [4:0] top;
        bit         done;
        int         kind;
        plan_state = '0;
        // Directed part: extreme ids, recursive locking, nested release.
        plan_beat(lodd_pkg::CMD_ACQUIRE, 5'd0,  1, lodd_pkg::ST_OK);
        plan_beat(lodd_pkg::CMD_ACQUIRE, 5'd0,  1, lodd_pkg::ST_OK);
        plan_beat(lodd_pkg::CMD_ACQUIRE, 5'd31, 1, lodd_pkg::ST_OK);
        plan_beat(lodd_pkg::CMD_RELEASE, 5'd31, 1, lodd_pkg::ST_OK);
        plan_beat(lodd_pkg::CMD_ACQUIRE, 5'd31, 1, lodd_pkg::ST_OK);
        plan_beat(lodd_pkg::CMD_RELEASE, 5'd31, 1, lodd_pkg::ST_OK);
        plan_beat(lodd_pkg::CMD_RELEASE, 5'd0,  1, lodd_pkg::ST_OK);
        plan_beat(lodd_pkg::CMD_RELEASE, 5'd0,  1, lodd_pkg::ST_OK);
        plan_beat(lodd_pkg::CMD_ACQUIRE, 5'd31, 1, lodd_pkg::ST_OK);
        plan_beat(lodd_pkg::CMD_ACQUIRE, 5'd31, 1, lodd_pkg::ST_OK);
        plan_beat(lodd_pkg::CMD_ACQUIRE, 5'd21, 0, lodd_pkg::ST_OK);
        plan_beat(lodd_pkg::CMD_ACQUIRE, 5'd10, 0, lodd_pkg::ST_OK);
        plan_beat(lodd_pkg::CMD_RELEASE, 5'd10, 0, lodd_pkg::ST_OK);
        plan_beat(lodd_pkg::CMD_RELEASE, 5'd21, 0, lodd_pkg::ST_OK);
        plan_beat(lodd_pkg::CMD_RELEASE, 5'd31, 0, lodd_pkg::ST_OK);
        plan_beat(lodd_pkg::CMD_RELEASE, 5'd31, 0, lodd_pkg::ST_OK);

        // Random well-formed traffic that never faults, so the search engine
        // keeps working on a growing graph.
        for (int i = 0; i < 500; i++) begin
            top = plan_state.held[plan_state.depth-1];
            if (plan_state.depth != 0 &&
                (plan_state.depth == 5'd16 || $urandom_range(0, 99) < 45)) begin
                plan_beat(lodd_pkg::CMD_RELEASE, top, 0, lodd_pkg::ST_OK);
                continue;
            end
            done = 1'b0;
            for (int k = 0; k < 8 && !done; k++) begin
                if (plan_state.depth != 0 && $urandom_range(0, 99) < 15) id = top;
                else id = 5'($urandom_range(0, 31));
                if (status_of(lodd_pkg::CMD_ACQUIRE, id) == lodd_pkg::ST_OK) begin
                    plan_beat(lodd_pkg::CMD_ACQUIRE, id, 0, lodd_pkg::ST_OK);
                    done = 1'b1;
                end
            end
            if (!done && plan_state.depth != 0)
                plan_beat(lodd_pkg::CMD_RELEASE, top, 0, lodd_pkg::ST_OK);
        end

        // One fault ends the run, since the halt is sticky until reset.
        kind = $urandom_range(0, 3);
        if (kind == 0) begin
            if (plan_state.depth == 0)
                plan_beat(lodd_pkg::CMD_ACQUIRE, 5'($urandom_range(0, 31)), 0,
                          lodd_pkg::ST_OK);
            done = 1'b0;
            for (int k = 0; k < 32 && !done; k++) begin
                if (status_of(lodd_pkg::CMD_ACQUIRE, 5'(k)) == lodd_pkg::ST_DEADLOCK) begin
                    plan_beat(lodd_pkg::CMD_ACQUIRE, 5'(k), 0, lodd_pkg::ST_OK);
                    done = 1'b1;
                end
            end
            if (!done) kind = 2;
        end
        if (kind == 1) begin
            if (plan_state.depth == 0)
                plan_beat(lodd_pkg::CMD_ACQUIRE, 5'($urandom_range(0, 31)), 0,
                          lodd_pkg::ST_OK);
            while (plan_state.depth < 5'd16)
                plan_beat(lodd_pkg::CMD_ACQUIRE, plan_state.held[plan_state.depth-1], 0,
                          lodd_pkg::ST_OK);
            plan_beat(lodd_pkg::CMD_ACQUIRE, 5'($urandom_range(0, 31)), 1,
                      lodd_pkg::ST_OVERFLOW);
        end else if (kind == 2) begin
            if (plan_state.depth == 0)
                plan_beat(lodd_pkg::CMD_ACQUIRE, 5'($urandom_range(0, 31)), 0,
                          lodd_pkg::ST_OK);
            top = plan_state.held[plan_state.depth-1];
            plan_beat(lodd_pkg::CMD_RELEASE, top ^ 5'($urandom_range(1, 31)), 1,
                      lodd_pkg::ST_INVALID_UNLOCK);
        end else if (kind == 3) begin
            while (plan_state.depth != 0)
                plan_beat(lodd_pkg::CMD_RELEASE, plan_state.held[plan_state.depth-1], 0,
                          lodd_pkg::ST_OK);
            plan_beat(lodd_pkg::CMD_RELEASE, 5'($urandom_range(0, 31)), 1,
                      lodd_pkg::ST_MULTI_UNLOCK);
        end
        for (int i = 0; i < 12; i++)
            plan_beat(lodd_pkg::t_cmd'($urandom_range(0, 1)), 5'($urandom_range(0, 31)), 1,
                      lodd_pkg::ST_HALTED);
    endtask

    // Result side: random stalls, one long hold-off to back the block up.
    initial begin
        int           hold_left;
        bit           pressure_done;
        t_lock_result want;
        t_lock_result got;
        hold_left     = 0;
        pressure_done = 1'b0;
        m_axis_tready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (m_axis_tvalid && m_axis_tready) begin
                got.status = lodd_pkg::t_status'(m_axis_tdata[2:0]);
                got.src    = m_axis_tdata[7:3];
                got.dst    = m_axis_tdata[12:8];
                if (pending_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result beat: status %0d from %0d to %0d",
                                 got.status, got.src, got.dst);
                end else begin
                    want = pending_results.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"mismatch: expected status %0d from %0d to %0d,",
                                      " got %0d %0d %0d"},
                                     want.status, want.src, want.dst,
                                     got.status, got.src, got.dst);
                    end
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else if (!pressure_done && accepted_beats >= 120) begin
                pressure_done = 1'b1;
                hold_left     = 400;
                m_axis_tready <= 1'b0;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                hold_left     = $urandom_range(0, 11);
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    initial begin
        t_lock_beat b;
        mismatches     = 0;
        accepted_beats = 0;
        calm           = 1'b0;
        i_rst_n        = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        build_plan();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < beat_plan.size(); i++) begin
            b = beat_plan[i];
            if (i >= beat_plan.size() - 60) calm = 1'b1;
            if (!calm && $urandom_range(0, 3) == 0) begin
                s_axis_tvalid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end
            s_axis_tvalid <= 1'b1;
            s_axis_tdata  <= {2'b00, b.id, b.cmd};
            do @(posedge i_clk); while (!s_axis_tready);
            pending_results.push_back(b.want);
            accepted_beats++;
        end
        s_axis_tvalid <= 1'b0;

        wait (pending_results.size() == 0);
        repeat (50) @(posedge i_clk);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule
